// ===== rtl/rlim_pkg.sv =====
package rlim_pkg;

   typedef struct packed {
      logic [7:0]  flow_id;
      logic [2:0]  severity;
      logic [2:0]  limit_mode;
      logic [31:0] frame_number;
      logic [47:0] tick_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] suppressed_total;
   } rsp_type;

   typedef struct packed {
      logic        emitted;
      logic [31:0] tokens;
      logic [47:0] refill_time;
      logic [31:0] suppressed;
   } ent_type;

   localparam logic [1:0] VERDICT_SUPPRESSED = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPTED   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID    = 2'd2;

   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_AUTO   = 3'd1;
   localparam logic [2:0] MODE_FIRST  = 3'd2;
   localparam logic [2:0] MODE_NTH    = 3'd3;
   localparam logic [2:0] MODE_BUCKET = 3'd4;

   localparam logic [2:0] SEV_WARN = 3'd3;

   localparam logic [1:0] CSR_FRAME_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_TOKEN_RATE     = 2'd1;
   localparam logic [1:0] CSR_BUCKET_BURST   = 2'd2;

   localparam logic [31:0] ONE_TOKEN = 32'd65536;
   localparam logic [31:0] SUPP_MAX  = 32'hFFFF_FFFF;

endpackage

// ===== rtl/rlim_table.sv =====
module rlim_table #(
   parameter int FLOWS = 256,
   parameter int IW = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [IW-1:0]            rd_addr,
   output rlim_pkg::ent_type        rd_data,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  rlim_pkg::ent_type        wr_data,
   output logic                     clr_busy
);
   import rlim_pkg::*;

   ent_type mem [FLOWS];
   ent_type rd_data_ff;
   logic [IW-1:0] clr_addr_ff;
   logic          clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == IW'(FLOWS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ===== rtl/rlim_mod.sv =====
module rlim_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] num,
   input  logic [15:0] den,
   output logic        done,
   output logic [15:0] rem
);
   logic [31:0] num_ff;
   logic [15:0] den_ff;
   logic [15:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [16:0] trial;

   assign trial = {rem_ff, num_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= 16'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[15:0];
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/rlim_mul.sv =====
module rlim_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [47:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [79:0] prod
);
   logic [47:0] a_ff;
   logic [31:0] b_ff;
   logic [79:0] acc_ff;
   logic [1:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [47:0] part;
   logic [79:0] part_sh;

   always_comb begin
      unique case (cnt_ff)
         2'd0:    part = 48'(a_ff[15:0] * b_ff);
         2'd1:    part = 48'(a_ff[31:16] * b_ff);
         default: part = 48'(a_ff[47:32] * b_ff);
      endcase
      unique case (cnt_ff)
         2'd0:    part_sh = {32'd0, part};
         2'd1:    part_sh = {16'd0, part, 16'd0};
         default: part_sh = {part, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 2'd2) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (run_ff) begin
         acc_ff <= acc_ff + part_sh;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/per_flow_event_rate_limiter.sv =====
// Per-flow event rate limiter.
// Request: drive req and raise start while busy is low; the event is taken at
// that edge. busy stays high until the result has been produced.
// Result: rsp_valid is high for exactly one cycle with rsp; the receiver
// cannot stall, so it must take the result in that cycle.
// Configuration: csr_we, csr_index and csr_wdata write the frame interval,
// token rate and bucket burst; write only while busy is low.
// Steps from the start edge to the result strobe: IDX, READ and DECIDE for
// every event; unlimited or invalid events answer from DECIDE, first-only go
// on to UPDATE, a fresh bucket to BUCKET and UPDATE, a bucket refill to MUL,
// BUCKET and UPDATE (the 48x32 refill multiply takes three 16-bit slices of
// elapsed time), and every-Nth-frame mode to MOD and UPDATE (the remainder
// unit retires one frame bit per cycle). busy drops with the result strobe,
// so a new event can be taken at the edge that ends the strobe, never sooner.
// Reset: a clearing pass over all FLOWS entries zeroes the flow table; busy is
// high throughout, no event is accepted. State, strobe and CSR registers reset.
module per_flow_event_rate_limiter #(
   parameter int FLOWS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rlim_pkg::req_type req,
   output logic              rsp_valid,
   output rlim_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import rlim_pkg::*;

   localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam logic [16:0] FLOW_RECIP = 17'((65536 + FLOWS - 1) / FLOWS);
   localparam logic [7:0]  FLOWS_LOW  = 8'(FLOWS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_IDX    = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_MOD    = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_BUCKET = 4'd6;
   localparam logic [3:0] ST_UPDATE = 4'd7;

   logic [3:0]  state_ff, state_in;
   req_type     req_ff;
   logic [7:0]  rem_ff, rem_in;
   logic [15:0] interval_ff;
   logic [31:0] rate_ff;
   logic [31:0] burst_ff;
   ent_type     ent_ff, ent_in;
   logic [31:0] tk_ff, tk_in;
   logic        acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        clr_busy;
   ent_type     rd_data;
   logic        rd_en;
   logic        wr_en;
   logic [IW-1:0] addr;
   logic [23:0] flow_q_wide;
   logic [7:0]  flow_q;
   logic [7:0]  flow_red;

   logic        mod_go, mod_done;
   logic [15:0] mod_rem;
   logic        mul_go, mul_done;
   logic [79:0] mul_prod;
   logic [47:0] elapsed;
   logic [2:0]  eff_mode;
   logic        invalid;
   logic [55:0] add_amt;
   logic [32:0] tk_sum;

   assign addr = IW'(rem_ff);

   rlim_table #(.FLOWS(FLOWS), .IW(IW)) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (addr),
      .wr_data  (ent_ff),
      .clr_busy (clr_busy)
   );

   rlim_mod u_mod (
      .clock (clock),
      .reset (reset),
      .go    (mod_go),
      .num   (req_ff.frame_number),
      .den   (interval_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   rlim_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (elapsed),
      .b     (rate_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd1;
         rate_ff     <= 32'd0;
         burst_ff    <= ONE_TOKEN;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_INTERVAL: interval_ff <= csr_wdata[15:0];
            CSR_TOKEN_RATE:     rate_ff     <= csr_wdata;
            CSR_BUCKET_BURST:   burst_ff    <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // reduce flow_id modulo FLOWS by reciprocal multiplication
   assign flow_q_wide = {16'd0, rem_ff} * {7'd0, FLOW_RECIP};
   assign flow_q      = flow_q_wide[23:16];
   assign flow_red    = (FLOWS >= 256) ? rem_ff : rem_ff - flow_q * FLOWS_LOW;

   assign elapsed = (req_ff.tick_time >= rd_data.refill_time) ?
                    req_ff.tick_time - rd_data.refill_time : 48'd0;
   assign eff_mode = (req_ff.limit_mode == MODE_AUTO) ?
                     ((req_ff.severity < SEV_WARN) ? MODE_FIRST : MODE_NONE) :
                     req_ff.limit_mode;
   assign invalid = (eff_mode > MODE_BUCKET) ||
                    (eff_mode == MODE_NTH && interval_ff == 16'd0) ||
                    (eff_mode == MODE_BUCKET &&
                     (rate_ff == 32'd0 || burst_ff < ONE_TOKEN));
   assign add_amt = mul_prod[63:8];
   assign tk_sum  = {1'b0, ent_ff.tokens} + {1'b0, add_amt[31:0]};

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      ent_in       = ent_ff;
      tk_in        = tk_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      mod_go       = 1'b0;
      mul_go       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !clr_busy) begin
               rem_in   = req.flow_id;
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            rem_in   = flow_red;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            ent_in  = rd_data;
            if (eff_mode == MODE_NONE) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{verdict: VERDICT_ACCEPTED,
                                suppressed_total: rd_data.suppressed};
               state_in     = ST_IDLE;
            end else if (invalid) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{verdict: VERDICT_INVALID,
                                suppressed_total: rd_data.suppressed};
               state_in     = ST_IDLE;
            end else if (eff_mode == MODE_FIRST) begin
               acc_in   = !rd_data.emitted;
               state_in = ST_UPDATE;
            end else if (eff_mode == MODE_NTH) begin
               mod_go   = 1'b1;
               state_in = ST_MOD;
            end else if (!rd_data.emitted) begin
               tk_in    = burst_ff;
               state_in = ST_BUCKET;
            end else begin
               mul_go   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               acc_in   = (mod_rem == 16'd0);
               state_in = ST_UPDATE;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (mul_prod[79:64] != 16'd0 || add_amt >= 56'(burst_ff) ||
                   tk_sum > {1'b0, burst_ff}) begin
                  tk_in = burst_ff;
               end else begin
                  tk_in = tk_sum[31:0];
               end
               state_in = ST_BUCKET;
            end
         end
         ST_BUCKET: begin
            acc_in             = (tk_ff >= ONE_TOKEN);
            ent_in.tokens      = (tk_ff >= ONE_TOKEN) ? tk_ff - ONE_TOKEN : tk_ff;
            ent_in.refill_time = req_ff.tick_time;
            state_in           = ST_UPDATE;
         end
         ST_UPDATE: begin
            wr_en        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in       = '{verdict: acc_ff ? VERDICT_ACCEPTED : VERDICT_SUPPRESSED,
                             suppressed_total: ent_ff.suppressed};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // apply the verdict to the entry as it is registered on entry to UPDATE
   ent_type ent_upd;
   always_comb begin
      ent_upd = ent_in;
      if (state_in == ST_UPDATE && state_ff != ST_UPDATE) begin
         if (acc_in) begin
            ent_upd.emitted = 1'b1;
         end else if (ent_in.suppressed != SUPP_MAX) begin
            ent_upd.suppressed = ent_in.suppressed + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start && !clr_busy) begin
         req_ff <= req;
      end
      rem_ff  <= rem_in;
      ent_ff  <= ent_upd;
      tk_ff   <= tk_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE) || clr_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_UPDATE || $past(state_ff) == ST_DECIDE))
      else $error("result strobe without a finished event");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.verdict != 2'd3)
      else $error("undefined verdict code");

   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> state_ff == ST_IDLE)
      else $error("event in progress during table clear");

   a_invalid_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.verdict == VERDICT_INVALID) |-> !$past(wr_en))
      else $error("invalid event updated the table");

endmodule
